/* src/espd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the encoder speed PID drive.
// Used by the core and by its port checker; depends on nothing else.
package espd_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  localparam int GAIN_W   = 16;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 3;
  localparam int SHORT_W  = 10;
  localparam int RPM_W    = 24;
  localparam int SP_W     = 16;
  localparam int DELTA_W  = 26;
  localparam int INTEG_W  = 25;
  localparam int DIFF_W   = 25;
  localparam int MUL_A_W  = 37;
  localparam int MUL_B_W  = 17;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 64;
  localparam int MAG_W    = 8;

  localparam int DELTA_CLIP   = 2 ** 24;
  localparam int SETPOINT_MAX = 130 * 256;
  localparam int INTEG_LIMIT  = 255 * 65536;
  localparam longint OUT_LIMIT = 64'sd255 * 64'sd16777216;
  localparam int S24_MAX = 8388607;
  localparam int S24_MIN = -8388608;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST  = 16'sd384;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST  = 16'sd20;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST  = 16'sd13;
  localparam logic [CFG_W-1:0]   RPC_RST      = 16'd1422;
  localparam logic [CFG_W-1:0]   DT_RST       = 16'd1311;
  localparam logic [SHORT_W-1:0] INV_DT_RST   = 10'd50;
  localparam logic [SHORT_W-1:0] INTERVAL_RST = 10'd20;
  localparam logic [SP_W-1:0]    TARGET_RST   = 16'd15360;

  typedef enum logic [1:0] {
    REQ_EDGE     = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_SETPOINT = 2'd2
  } req_e;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_RPC       = 3'd3,
    REG_DT        = 3'd4,
    REG_INV_DT    = 3'd5,
    REG_INTERVAL  = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_RPM,
    ST_ERR,
    ST_MUL_I,
    ST_INTEG,
    ST_MUL_D,
    ST_MUL_GD,
    ST_MUL_GP,
    ST_MUL_GI,
    ST_SUM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]      req_type;
    logic            b_level;
    logic [SP_W-1:0] new_setpoint;
  } in_t;

  typedef struct packed {
    logic [MAG_W-1:0]        drive_magnitude;
    logic                    dir_a;
    logic                    dir_b;
    logic signed [RPM_W-1:0] measured_rpm;
    logic signed [RPM_W-1:0] speed_error;
  } out_t;

  // Saturate a signed value to the signed 24 bit range.
  function automatic logic signed [RPM_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
    logic signed [RPM_W-1:0] r;
    if (v > ACC_W'(S24_MAX)) begin
      r = RPM_W'(S24_MAX);
    end else if (v < ACC_W'(S24_MIN)) begin
      r = RPM_W'(S24_MIN);
    end else begin
      r = v[RPM_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/encoder_speed_pid_drive_core.sv */
`timescale 1ns / 1ps
// Encoder speed PID drive: event decode, tick interval and PID sequencer.
// One shared signed multiplier serves every product. Depends on espd_pkg.
//
//   channel  | direction | handshake                  | word
//   ---------+-----------+----------------------------+-------------------
//   input    | in        | in_valid_i / in_stall_o    | espd_pkg::in_t
//   result   | out       | out_valid_o / out_stall_i  | espd_pkg::out_t
//   config   | in        | cfg_we_i, no wait          | cfg_idx_i, cfg_data_i
//
// Edge, setpoint and non-updating tick words never make the block busy.
// A tick that closes the interval runs the eleven step sequence through the shared
// multiplier; the result register is loaded in the final step, the block then returns
// to idle and takes the next word, and a stalled result register holds the final step.
// Reset is asynchronous and loads the register defaults and the 60 RPM target.
module encoder_speed_pid_drive_core #(
  parameter int COUNT_WIDTH = espd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  espd_pkg::in_t                in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output espd_pkg::out_t               out_word_o,
  input  logic                         cfg_we_i,
  input  logic [espd_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [espd_pkg::CFG_W-1:0]   cfg_data_i
);

  localparam int EXT_W = (COUNT_WIDTH > espd_pkg::DELTA_W) ? COUNT_WIDTH : espd_pkg::DELTA_W;
  localparam int ERR_W = espd_pkg::SP_W + 10;
  localparam int ISUM_W = espd_pkg::PROD_W + 1;
  localparam int ABS_W = 33;

  // Configuration registers
  logic signed [espd_pkg::GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [espd_pkg::CFG_W-1:0]         rpc_q, dt_q;
  logic [espd_pkg::SHORT_W-1:0]       inv_dt_q, interval_q;

  // Controller state
  logic [COUNT_WIDTH-1:0]               count_q, last_q;
  logic [espd_pkg::SHORT_W-1:0]         tick_q;
  logic signed [espd_pkg::INTEG_W-1:0]  integ_q;
  logic signed [espd_pkg::RPM_W-1:0]    prev_q;
  logic [espd_pkg::SP_W-1:0]            target_q;
  espd_pkg::state_e                     state_q, state_d;

  // Working registers of the sequence
  logic signed [espd_pkg::DELTA_W-1:0]  delta_q;
  logic signed [espd_pkg::PROD_W-1:0]   prod_q;
  logic signed [espd_pkg::ACC_W-1:0]    acc_q;
  logic signed [espd_pkg::DIFF_W-1:0]   diff_q;
  logic signed [espd_pkg::RPM_W-1:0]    rpm_q, err_q;

  logic           out_valid_q;
  espd_pkg::out_t out_q;

  logic accept, is_tick, update;
  logic [espd_pkg::SHORT_W-1:0] tick_inc;
  logic out_free;

  logic signed [espd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [espd_pkg::MUL_B_W-1:0] mul_b;
  logic signed [espd_pkg::PROD_W-1:0]  mul_p;
  logic                                mul_en;

  logic signed [EXT_W-1:0]              ud_ext;
  logic signed [espd_pkg::DELTA_W-1:0]  delta_d;
  logic signed [espd_pkg::RPM_W-1:0]    rpm_d, err_d;
  logic signed [ERR_W-1:0]              err_wide;
  logic signed [ISUM_W-1:0]             isum;
  logic signed [espd_pkg::INTEG_W-1:0]  integ_d;
  espd_pkg::out_t                       res_d;
  logic signed [ABS_W-1:0]              acc_abs;
  logic [espd_pkg::MAG_W-1:0]           mag;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != espd_pkg::ST_IDLE);
  assign is_tick    = (in_word_i.req_type == espd_pkg::REQ_TICK);
  assign tick_inc   = tick_q + espd_pkg::SHORT_W'(1);
  assign update     = accept && is_tick && (tick_inc >= interval_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      espd_pkg::ST_IDLE:   if (update) state_d = espd_pkg::ST_DELTA;
      espd_pkg::ST_DELTA:  state_d = espd_pkg::ST_RPM;
      espd_pkg::ST_RPM:    state_d = espd_pkg::ST_ERR;
      espd_pkg::ST_ERR:    state_d = espd_pkg::ST_MUL_I;
      espd_pkg::ST_MUL_I:  state_d = espd_pkg::ST_INTEG;
      espd_pkg::ST_INTEG:  state_d = espd_pkg::ST_MUL_D;
      espd_pkg::ST_MUL_D:  state_d = espd_pkg::ST_MUL_GD;
      espd_pkg::ST_MUL_GD: state_d = espd_pkg::ST_MUL_GP;
      espd_pkg::ST_MUL_GP: state_d = espd_pkg::ST_MUL_GI;
      espd_pkg::ST_MUL_GI: state_d = espd_pkg::ST_SUM;
      espd_pkg::ST_SUM:    state_d = espd_pkg::ST_OUT;
      espd_pkg::ST_OUT:    if (out_free) state_d = espd_pkg::ST_IDLE;
      default:             state_d = espd_pkg::ST_IDLE;
    endcase
  end

  // Multiplier operand selection per step
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state_q)
      espd_pkg::ST_RPM: begin
        mul_a = espd_pkg::MUL_A_W'(delta_q);
        mul_b = $signed({1'b0, rpc_q});
      end
      espd_pkg::ST_MUL_I: begin
        mul_a = espd_pkg::MUL_A_W'(err_q);
        mul_b = $signed({1'b0, dt_q});
      end
      espd_pkg::ST_MUL_D: begin
        mul_a = espd_pkg::MUL_A_W'(diff_q);
        mul_b = $signed({{(espd_pkg::MUL_B_W - espd_pkg::SHORT_W){1'b0}}, inv_dt_q});
      end
      espd_pkg::ST_MUL_GD: begin
        // The derivative product fits the operand width.
        mul_a = $signed(prod_q[espd_pkg::MUL_A_W-1:0]);
        mul_b = espd_pkg::MUL_B_W'(gain_d_q);
      end
      espd_pkg::ST_MUL_GP: begin
        mul_a = espd_pkg::MUL_A_W'(err_q);
        mul_b = espd_pkg::MUL_B_W'(gain_p_q);
      end
      espd_pkg::ST_MUL_GI: begin
        mul_a = espd_pkg::MUL_A_W'(integ_q);
        mul_b = espd_pkg::MUL_B_W'(gain_i_q);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Count delta read as signed, limited to plus or minus two to the 24th.
  always_comb begin
    ud_ext = EXT_W'($signed(count_q - last_q));
    if (ud_ext > EXT_W'(espd_pkg::DELTA_CLIP)) begin
      delta_d = espd_pkg::DELTA_W'(espd_pkg::DELTA_CLIP);
    end else if (ud_ext < -EXT_W'(espd_pkg::DELTA_CLIP)) begin
      delta_d = -espd_pkg::DELTA_W'(espd_pkg::DELTA_CLIP);
    end else begin
      delta_d = ud_ext[espd_pkg::DELTA_W-1:0];
    end
  end

  always_comb begin
    rpm_d    = espd_pkg::sat24(espd_pkg::ACC_W'(prod_q));
    err_wide = $signed({{(ERR_W - espd_pkg::SP_W){1'b0}}, target_q}) - ERR_W'(rpm_d);
    err_d    = espd_pkg::sat24(espd_pkg::ACC_W'(err_wide));
  end

  // The arithmetic shift gives the floor of the Q16.24 product divided by 256.
  always_comb begin
    isum = ISUM_W'(integ_q) + ISUM_W'(prod_q >>> 8);
    if (isum > ISUM_W'(espd_pkg::INTEG_LIMIT)) begin
      integ_d = espd_pkg::INTEG_W'(espd_pkg::INTEG_LIMIT);
    end else if (isum < -ISUM_W'(espd_pkg::INTEG_LIMIT)) begin
      integ_d = -espd_pkg::INTEG_W'(espd_pkg::INTEG_LIMIT);
    end else begin
      integ_d = isum[espd_pkg::INTEG_W-1:0];
    end
  end

  // Output clamp and sign and magnitude drive; zero magnitude brakes.
  always_comb begin
    acc_abs = acc_q[ABS_W-1:0];
    if (acc_q > espd_pkg::ACC_W'(espd_pkg::OUT_LIMIT) ||
        acc_q < -espd_pkg::ACC_W'(espd_pkg::OUT_LIMIT)) begin
      mag = '1;
    end else begin
      if (acc_q[espd_pkg::ACC_W-1]) acc_abs = -acc_q[ABS_W-1:0];
      mag = acc_abs[31:24];
    end
    res_d.drive_magnitude = mag;
    res_d.measured_rpm    = rpm_q;
    res_d.speed_error     = err_q;
    if (mag == '0) begin
      res_d.dir_a = 1'b1;
      res_d.dir_b = 1'b1;
    end else if (!acc_q[espd_pkg::ACC_W-1]) begin
      res_d.dir_a = 1'b1;
      res_d.dir_b = 1'b0;
    end else begin
      res_d.dir_a = 1'b0;
      res_d.dir_b = 1'b1;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= espd_pkg::ST_IDLE;
      gain_p_q    <= espd_pkg::GAIN_P_RST;
      gain_i_q    <= espd_pkg::GAIN_I_RST;
      gain_d_q    <= espd_pkg::GAIN_D_RST;
      rpc_q       <= espd_pkg::RPC_RST;
      dt_q        <= espd_pkg::DT_RST;
      inv_dt_q    <= espd_pkg::INV_DT_RST;
      interval_q  <= espd_pkg::INTERVAL_RST;
      count_q     <= '0;
      last_q      <= '0;
      tick_q      <= '0;
      integ_q     <= '0;
      prev_q      <= '0;
      target_q    <= espd_pkg::TARGET_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          espd_pkg::REG_GAIN_P:   gain_p_q   <= $signed(cfg_data_i);
          espd_pkg::REG_GAIN_I:   gain_i_q   <= $signed(cfg_data_i);
          espd_pkg::REG_GAIN_D:   gain_d_q   <= $signed(cfg_data_i);
          espd_pkg::REG_RPC:      rpc_q      <= cfg_data_i;
          espd_pkg::REG_DT:       dt_q       <= cfg_data_i;
          espd_pkg::REG_INV_DT:   inv_dt_q   <= cfg_data_i[espd_pkg::SHORT_W-1:0];
          espd_pkg::REG_INTERVAL: interval_q <= cfg_data_i[espd_pkg::SHORT_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        unique case (in_word_i.req_type)
          espd_pkg::REQ_EDGE: begin
            if (in_word_i.b_level) count_q <= count_q + COUNT_WIDTH'(1);
            else                   count_q <= count_q - COUNT_WIDTH'(1);
          end
          espd_pkg::REQ_TICK: begin
            tick_q <= update ? '0 : tick_inc;
          end
          espd_pkg::REQ_SETPOINT: begin
            if (in_word_i.new_setpoint <= espd_pkg::SP_W'(espd_pkg::SETPOINT_MAX)) begin
              target_q <= in_word_i.new_setpoint;
              integ_q  <= '0;
            end
          end
          default: ;
        endcase
      end

      if (state_q == espd_pkg::ST_DELTA) last_q <= count_q;
      if (state_q == espd_pkg::ST_INTEG) begin
        integ_q <= integ_d;
        prev_q  <= err_q;
      end

      if (state_q == espd_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= mul_p;
    unique case (state_q)
      espd_pkg::ST_DELTA: delta_q <= delta_d;
      espd_pkg::ST_ERR: begin
        rpm_q <= rpm_d;
        err_q <= err_d;
      end
      espd_pkg::ST_INTEG:  diff_q <= espd_pkg::DIFF_W'(err_q) - espd_pkg::DIFF_W'(prev_q);
      espd_pkg::ST_MUL_GP: acc_q  <= espd_pkg::ACC_W'(prod_q) <<< 8;
      espd_pkg::ST_MUL_GI: acc_q  <= acc_q + (espd_pkg::ACC_W'(prod_q) <<< 8);
      espd_pkg::ST_SUM:    acc_q  <= acc_q + espd_pkg::ACC_W'(prod_q);
      espd_pkg::ST_OUT:    if (out_free) out_q <= res_d;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* src/espd_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the encoder speed PID drive, bound to its top level.
// Depends on espd_pkg for the word types and request codes.
module espd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input espd_pkg::in_t  in_word_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input espd_pkg::out_t out_word_o
);

  // A stalled result word stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // A new result only appears at the end of a busy update sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an update sequence");

  // Only a tick word can start the busy sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |->
      $past(in_valid_i && in_word_i.req_type == espd_pkg::REQ_TICK))
    else $error("sequence started without a tick word");

  // Edge and setpoint words never make the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.req_type != espd_pkg::REQ_TICK
      |=> !in_stall_o)
    else $error("non-tick word made the block busy");

endmodule

bind encoder_speed_pid_drive_core espd_checker u_espd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
